### hdl/eafd_pkg.sv
// ----------------------------------------------------------------------------
// eafd_pkg - shared types and constants of the escaped API frame deframer
// Holds the framing codes, the receive phase and the operation record that
// the front end hands to the back end through the operation queue.
// ----------------------------------------------------------------------------
package eafd_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h7E;
  localparam logic [7:0]  ESCAPE_BYTE   = 8'h7D;
  localparam logic [7:0]  ESCAPE_MASK   = 8'h20;
  localparam logic [7:0]  CHECK_GOOD    = 8'hFF;
  localparam logic [16:0] FRAMING_BYTES = 17'd4;

  localparam logic [1:0]  MODE_TRANSPARENT = 2'd0;

  localparam int POS_W = 17;
  localparam int LEN_W = 16;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SKIP,
    PH_COLLECT
  } rx_phase_t;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_START,
    OP_DATA
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             frame_end;
    logic             add_sum;
  } op_t;

endpackage

### hdl/eafd_ifs.sv
// ----------------------------------------------------------------------------
// eafd_ifs - channel interfaces of the escaped API frame deframer
// Valid/ready channels for raw received bytes and for deframed bytes.
// ----------------------------------------------------------------------------
interface eafd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface eafd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic [16:0] byte_position;
  logic        frame_end;
  logic        checksum_ok;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_end, output checksum_ok, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input frame_end, input checksum_ok, output ready);
endinterface

### hdl/eafd_front.sv
// ----------------------------------------------------------------------------
// eafd_front - receive front end
// Hunts for the start byte, strips escapes, tracks position and length, and
// classifies each byte into an operation for the back end.
// ----------------------------------------------------------------------------
module eafd_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [1:0]              frame_mode,
  eafd_in_if.sink                 rx,
  input  logic                    q_not_full,
  output logic                    q_push,
  output eafd_pkg::op_t           q_op
);

  eafd_pkg::rx_phase_t                phase, phase_next;
  logic                               esc_pend, esc_pend_next;
  logic [eafd_pkg::POS_W-1:0]         count, count_next;
  logic [eafd_pkg::LEN_W-1:0]         length, length_next;

  logic                               accept;
  logic                               transparent;
  logic                               esc_mode;
  logic                               pend_eff;
  logic                               is_start;
  logic                               is_esc;
  logic [7:0]                         data_u;
  logic [eafd_pkg::POS_W-1:0]         count_inc;
  logic                               at_len_hi;
  logic                               at_len_lo;
  logic                               last_byte;

  assign rx.ready    = q_not_full;
  assign accept      = rx.valid & q_not_full;
  assign transparent = (frame_mode == eafd_pkg::MODE_TRANSPARENT);
  assign esc_mode    = frame_mode[1];
  assign pend_eff    = esc_mode & esc_pend;
  assign is_start    = (rx.rx_byte == eafd_pkg::START_BYTE);
  assign is_esc      = (rx.rx_byte == eafd_pkg::ESCAPE_BYTE);
  assign data_u      = pend_eff ? (rx.rx_byte ^ eafd_pkg::ESCAPE_MASK) : rx.rx_byte;
  assign count_inc   = count + 17'd1;
  assign at_len_hi   = (count == 17'd1);
  assign at_len_lo   = (count == 17'd2);
  assign last_byte   = (count >= 17'd3) &&
                       (count_inc == ({1'b0, length} + eafd_pkg::FRAMING_BYTES));

  // next state
  always_comb begin
    phase_next    = phase;
    esc_pend_next = esc_pend;
    count_next    = count;
    length_next   = length;
    if (accept) begin
      if (transparent) begin
        phase_next    = eafd_pkg::PH_HUNT;
        esc_pend_next = 1'b0;
        count_next    = '0;
        length_next   = '0;
      end else if (phase == eafd_pkg::PH_HUNT) begin
        if (is_start) begin
          phase_next    = eafd_pkg::PH_SKIP;
          esc_pend_next = 1'b0;
          count_next    = 17'd1;
          length_next   = '0;
        end
      end else if (phase == eafd_pkg::PH_SKIP && !pend_eff && is_start) begin
        esc_pend_next = 1'b0;
      end else if (esc_mode && !esc_pend && is_esc) begin
        esc_pend_next = 1'b1;
      end else if (last_byte) begin
        phase_next    = eafd_pkg::PH_HUNT;
        esc_pend_next = 1'b0;
        count_next    = '0;
        length_next   = '0;
      end else begin
        phase_next    = eafd_pkg::PH_COLLECT;
        esc_pend_next = 1'b0;
        count_next    = count_inc;
        if (at_len_hi) begin
          length_next = {data_u, length[7:0]};
        end else if (at_len_lo) begin
          length_next = {length[15:8], data_u};
        end
      end
    end
  end

  // operation issue
  always_comb begin
    q_push         = 1'b0;
    q_op.kind      = eafd_pkg::OP_DATA;
    q_op.data      = data_u;
    q_op.pos       = count;
    q_op.frame_end = last_byte;
    q_op.add_sum   = !(at_len_hi || at_len_lo);
    if (accept) begin
      if (transparent) begin
        q_push         = 1'b1;
        q_op.kind      = eafd_pkg::OP_PASS;
        q_op.data      = rx.rx_byte;
        q_op.pos       = '0;
        q_op.frame_end = 1'b1;
      end else if (phase == eafd_pkg::PH_HUNT) begin
        q_push         = is_start;
        q_op.kind      = eafd_pkg::OP_START;
        q_op.data      = rx.rx_byte;
        q_op.pos       = '0;
        q_op.frame_end = 1'b0;
      end else if (phase == eafd_pkg::PH_SKIP && !pend_eff && is_start) begin
        q_push = 1'b0;
      end else if (esc_mode && !esc_pend && is_esc) begin
        q_push = 1'b0;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= eafd_pkg::PH_HUNT;
      esc_pend <= 1'b0;
      count    <= '0;
      length   <= '0;
    end else begin
      phase    <= phase_next;
      esc_pend <= esc_pend_next;
      count    <= count_next;
      length   <= length_next;
    end
  end

endmodule

### hdl/eafd_queue.sv
// ----------------------------------------------------------------------------
// eafd_queue - operation queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module eafd_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  eafd_pkg::op_t push_op,
  output logic          not_full,
  input  logic          pop,
  output eafd_pkg::op_t pop_op,
  output logic          not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  eafd_pkg::op_t  slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  level;

  assign not_full  = (level != CW'(DEPTH));
  assign not_empty = (level != '0);
  assign pop_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      // hold the level when both sides move
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

### hdl/eafd_back.sv
// ----------------------------------------------------------------------------
// eafd_back - deframer back end
// Carries out queued operations: keeps the running checksum and loads the
// output register with each deframed byte.
// ----------------------------------------------------------------------------
module eafd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  eafd_pkg::op_t q_op,
  output logic          q_pop,
  eafd_out_if.source    tx
);

  logic [7:0]                 sum, sum_next;
  logic [7:0]                 sum_add;
  logic                       out_valid;
  logic [7:0]                 out_byte, out_byte_next;
  logic [eafd_pkg::POS_W-1:0] out_pos, out_pos_next;
  logic                       out_end, out_end_next;
  logic                       out_ok, out_ok_next;
  logic                       load;

  assign load    = !out_valid || tx.ready;
  assign q_pop   = q_not_empty && load;
  assign sum_add = q_op.add_sum ? (sum + q_op.data) : sum;

  always_comb begin
    sum_next      = sum;
    out_byte_next = q_op.data;
    out_pos_next  = q_op.pos;
    out_end_next  = q_op.frame_end;
    out_ok_next   = 1'b0;
    unique case (q_op.kind)
      eafd_pkg::OP_PASS: begin
        sum_next    = '0;
        out_ok_next = 1'b1;
      end
      eafd_pkg::OP_START: begin
        sum_next = '0;
      end
      eafd_pkg::OP_DATA: begin
        if (q_op.frame_end) begin
          sum_next    = '0;
          out_ok_next = (sum_add == eafd_pkg::CHECK_GOOD);
        end else begin
          sum_next = sum_add;
        end
      end
      default: begin
        sum_next = sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte <= out_byte_next;
      out_pos  <= out_pos_next;
      out_end  <= out_end_next;
      out_ok   <= out_ok_next;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.frame_byte    = out_byte;
  assign tx.byte_position = out_pos;
  assign tx.frame_end     = out_end;
  assign tx.checksum_ok   = out_ok;

endmodule

### hdl/escaped_api_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// escaped_api_frame_deframer_unit - API frame deframer with byte unescaping
// Turns a stream of raw serial bytes into deframed bytes with positions.
//
// Channels: rx carries one raw byte per transfer; tx carries one deframed
// byte per transfer with its frame position, a frame-end mark and, on the
// frame end, the checksum verdict. Non-start bytes while hunting, repeated start
// bytes and escape bytes that open an escape produce no transfer on tx.
// Configuration: cfg_we/cfg_data write the frame mode (0 pass-through,
// 1 framed, 2 or 3 framed with escaping); write it only while the block is idle.
// Throughput: one byte per cycle while tx takes bytes and the queue has room.
// The front end updates its receive phase, escape flag, position and length
// as each byte is accepted, and the back end folds one byte a cycle into the
// checksum while its output register is free. An accepted byte goes into the
// operation queue, then into the output register, from which it shows on tx.
// Stall: when tx is held off, the output register holds its byte, the queue
// fills, and rx.ready drops once the queue is full; nothing is lost.
// Reset: rst clears the receive phase to hunting, all frame state, the
// checksum, the queue and the output valid; the mode returns to pass-through.
// ----------------------------------------------------------------------------
module escaped_api_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  eafd_in_if.sink    rx,
  eafd_out_if.source tx,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  logic [1:0]    frame_mode;
  logic          q_push;
  logic          q_pop;
  logic          q_not_full;
  logic          q_not_empty;
  eafd_pkg::op_t q_in_op;
  eafd_pkg::op_t q_out_op;

  // mode register; takes effect from the next byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= eafd_pkg::MODE_TRANSPARENT;
    end else if (cfg_we) begin
      frame_mode <= cfg_data;
    end
  end

  // classify incoming bytes
  eafd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_mode (frame_mode),
    .rx         (rx),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_op       (q_in_op)
  );

  // decouple front and back
  eafd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (q_in_op),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .pop_op    (q_out_op),
    .not_empty (q_not_empty)
  );

  // checksum and output register
  eafd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_op        (q_out_op),
    .q_pop       (q_pop),
    .tx          (tx)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_not_full)
    else $error("operation queue overflow");

  // Checksum verdict only on a frame end.
  a_ok_on_end: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && !tx.frame_end) |-> !tx.checksum_ok)
    else $error("checksum_ok outside frame end");

  // A byte at position zero that does not end a frame is a start byte.
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && !tx.frame_end && tx.byte_position == 17'd0)
      |-> (tx.frame_byte == eafd_pkg::START_BYTE))
    else $error("frame opened by a non-start byte");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the escaped API frame deframer
// Feeds raw serial bytes through the rx channel, predicts every deframed
// byte with a cycle-free model of the receive phases, escape handling,
// length counting and checksum, and checks each tx transfer in order.
// A short directed table comes first, then random framed traffic in all
// mode settings under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  // mode settings beyond pass-through
  localparam logic [1:0] MODE_FRAMED      = 2'd1;
  localparam logic [1:0] MODE_ESCAPED     = 2'd2;
  localparam logic [1:0] MODE_ESCAPED_ALT = 2'd3;

  // Cycles to let pass after the last expected byte before touching the mode.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 84;
  localparam int REPORT_LIMIT  = 10;
  localparam int DIR_ROWS      = 28;

  typedef struct packed {
    logic [7:0]  fbyte;
    logic [16:0] fpos;
    logic        fend;
    logic        cok;
  } deframed_t;

  // ROW_MODE writes the mode, ROW_BYTE is checked against the predictor,
  // ROW_GIVEN carries its expected transfer, ROW_SILENT must give none.
  typedef enum logic [1:0] {
    ROW_MODE,
    ROW_BYTE,
    ROW_GIVEN,
    ROW_SILENT
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] val;
    deframed_t  want;
  } stim_row_t;

  typedef struct packed {
    logic [1:0] mode;
    int         idle_pct;
    int         stall_pct;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_data;

  eafd_in_if  rx_ch ();
  eafd_out_if tx_ch ();

  escaped_api_frame_deframer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .tx       (tx_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state, kept in step with every accepted rx transfer
  logic [1:0]          model_mode;
  eafd_pkg::rx_phase_t model_phase;
  logic                model_esc;
  logic [16:0]         model_count;
  logic [15:0]         model_len;
  logic [7:0]          model_sum;

  deframed_t deframed_q[$];   // expected tx transfers, oldest first
  int        fail_count = 0;
  int        rx_count   = 0;
  int        idle_pct   = 0;
  int        stall_pct  = 0;

  // Directed table: edges of the byte range, all modes, repeated start,
  // zero length, bad checksum, escapes in both escaping modes.
  stim_row_t directed_tab [DIR_ROWS] = '{
    '{ROW_GIVEN,  8'h00, '{8'h00, 17'd0, 1'b1, 1'b1}},   // pass-through after reset
    '{ROW_GIVEN,  8'hFF, '{8'hFF, 17'd0, 1'b1, 1'b1}},
    '{ROW_MODE,   {6'd0, MODE_FRAMED}, '0},
    '{ROW_SILENT, eafd_pkg::ESCAPE_BYTE, '0},             // hunting drops non-start
    '{ROW_GIVEN,  eafd_pkg::START_BYTE, '{eafd_pkg::START_BYTE, 17'd0, 1'b0, 1'b0}},
    '{ROW_SILENT, eafd_pkg::START_BYTE, '0},              // repeated start skipped
    '{ROW_BYTE,   8'h00, '0},
    '{ROW_BYTE,   8'h00, '0},
    '{ROW_GIVEN,  8'hFF, '{8'hFF, 17'd3, 1'b1, 1'b1}},   // zero length, good sum
    '{ROW_BYTE,   eafd_pkg::START_BYTE, '0},
    '{ROW_BYTE,   8'h00, '0},
    '{ROW_BYTE,   8'h02, '0},
    '{ROW_BYTE,   eafd_pkg::ESCAPE_BYTE, '0},             // plain data when unescaped
    '{ROW_BYTE,   eafd_pkg::START_BYTE, '0},              // start byte as data
    '{ROW_GIVEN,  8'h05, '{8'h05, 17'd5, 1'b1, 1'b0}},   // bad checksum
    '{ROW_MODE,   {6'd0, MODE_ESCAPED}, '0},
    '{ROW_BYTE,   eafd_pkg::START_BYTE, '0},
    '{ROW_BYTE,   8'h00, '0},
    '{ROW_SILENT, eafd_pkg::ESCAPE_BYTE, '0},
    '{ROW_BYTE,   8'h22, '0},
    '{ROW_SILENT, eafd_pkg::ESCAPE_BYTE, '0},
    '{ROW_BYTE,   eafd_pkg::ESCAPE_BYTE, '0},             // escape after escape
    '{ROW_SILENT, eafd_pkg::ESCAPE_BYTE, '0},
    '{ROW_BYTE,   8'h5E, '0},
    '{ROW_BYTE,   8'h24, '0},
    '{ROW_MODE,   {6'd0, MODE_ESCAPED_ALT}, '0},
    '{ROW_BYTE,   eafd_pkg::START_BYTE, '0},
    '{ROW_SILENT, eafd_pkg::ESCAPE_BYTE, '0}              // left pending into next mode
  };

  phase_t phase_tab [8] = '{
    '{MODE_FRAMED,                0,  0},
    '{MODE_ESCAPED,               64, 0},
    '{eafd_pkg::MODE_TRANSPARENT, 0,  64},
    '{MODE_ESCAPED_ALT,           28, 28},
    '{MODE_FRAMED,                0,  64},
    '{MODE_ESCAPED,               28, 28},
    '{MODE_FRAMED,                64, 0},
    '{MODE_ESCAPED,               0,  0}
  };

  function automatic void clear_frame_state();
    model_phase = eafd_pkg::PH_HUNT;
    model_esc   = 1'b0;
    model_count = '0;
    model_len   = '0;
    model_sum   = '0;
  endfunction

  // Advance the receive state by one raw byte; return 1 when it yields a
  // deframed byte.
  function automatic bit deframe_byte(input logic [7:0] raw, output deframed_t res);
    logic [7:0]  b;
    logic [16:0] at;
    b   = raw;
    res = '0;
    if (model_mode == eafd_pkg::MODE_TRANSPARENT) begin
      clear_frame_state();
      res = '{raw, 17'd0, 1'b1, 1'b1};
      return 1'b1;
    end
    if (!model_mode[1]) model_esc = 1'b0;
    if (model_phase == eafd_pkg::PH_HUNT) begin
      if (b != eafd_pkg::START_BYTE) return 1'b0;
      clear_frame_state();
      model_phase = eafd_pkg::PH_SKIP;
      model_count = 17'd1;
      res = '{b, 17'd0, 1'b0, 1'b0};
      return 1'b1;
    end
    if (model_phase == eafd_pkg::PH_SKIP && !model_esc && b == eafd_pkg::START_BYTE)
      return 1'b0;
    if (model_mode[1] && !model_esc && b == eafd_pkg::ESCAPE_BYTE) begin
      model_esc = 1'b1;
      return 1'b0;
    end
    if (model_esc) begin
      b = b ^ eafd_pkg::ESCAPE_MASK;
      model_esc = 1'b0;
    end
    model_phase = eafd_pkg::PH_COLLECT;
    at = model_count;
    if (at == 17'd1) model_len = {b, 8'h00};
    else if (at == 17'd2) model_len[7:0] = b;
    else model_sum = model_sum + b;
    model_count = model_count + 17'd1;
    if (at >= 17'd3 && model_count == {1'b0, model_len} + eafd_pkg::FRAMING_BYTES) begin
      res = '{b, at, 1'b1, model_sum == eafd_pkg::CHECK_GOOD};
      clear_frame_state();
    end else begin
      res = '{b, at, 1'b0, 1'b0};
    end
    return 1'b1;
  endfunction

  task automatic note_failure(input string what, input deframed_t exp_v,
                              input deframed_t got_v);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%s: expected byte %h pos %0d end %b ok %b, got byte %h pos %0d end %b ok %b",
               what, exp_v.fbyte, exp_v.fpos, exp_v.fend, exp_v.cok,
               got_v.fbyte, got_v.fpos, got_v.fend, got_v.cok);
  endtask

  // Present one byte and hold it until the transfer; valid stays high after
  // it so a following byte can go out back to back.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    rx_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    deframed_t res;
    push_byte(b);
    if (deframe_byte(b, res)) deframed_q = {deframed_q, res};
  endtask

  // Escape start and escape bytes in the escaping modes, plus a few others
  // at random, since the block unescapes whatever follows an escape.
  task automatic send_stuffed(input logic [7:0] b);
    if (model_mode[1] && (b == eafd_pkg::START_BYTE || b == eafd_pkg::ESCAPE_BYTE ||
                          $urandom_range(15) == 0))
    begin
      send_byte(eafd_pkg::ESCAPE_BYTE);
      send_byte(b ^ eafd_pkg::ESCAPE_MASK);
    end else begin
      send_byte(b);
    end
  endtask

  // Send one frame of the given length; cut drops its tail at random and a
  // quarter of the frames carry a random checksum.
  task automatic send_frame(input logic [15:0] flen, input bit cut);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         keep;
    body = {};
    sum  = '0;
    body = {body, flen[15:8]};
    body = {body, flen[7:0]};
    for (int i = 0; i < flen; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      body = {body, b};
    end
    b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : eafd_pkg::CHECK_GOOD - sum;
    body = {body, b};
    keep = cut ? $urandom_range(body.size() - 1) : body.size();
    send_byte(eafd_pkg::START_BYTE);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_byte(eafd_pkg::START_BYTE);
    for (int i = 0; i < keep; i++) send_stuffed(body[i]);
  endtask

  // Lower valid and hold until every expected transfer is out, then let the
  // pipeline settle in case the last bytes gave no transfer.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_mode(input logic [1:0] m);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_mode = m;
  endtask

  // Receiver: check every tx transfer against the oldest expectation and
  // choose ready for the next edge.
  always @(posedge clk) begin : tx_check
    deframed_t got_v;
    deframed_t exp_v;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      got_v = '{tx_ch.frame_byte, tx_ch.byte_position, tx_ch.frame_end, tx_ch.checksum_ok};
      if (deframed_q.size() == 0) begin
        note_failure("unexpected transfer", '0, got_v);
      end else begin
        exp_v = deframed_q.pop_front();
        if (got_v.fbyte !== exp_v.fbyte || got_v.fpos !== exp_v.fpos ||
            got_v.fend !== exp_v.fend || got_v.cok !== exp_v.cok)
          note_failure("mismatch", exp_v, got_v);
      end
    end
    tx_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin : stimulus
    deframed_t res;
    bit        made;
    int        phase_end;
    int        pick;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = eafd_pkg::MODE_TRANSPARENT;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    model_mode    = eafd_pkg::MODE_TRANSPARENT;
    clear_frame_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table with no idling on either side.
    foreach (directed_tab[i]) begin
      if (directed_tab[i].kind == ROW_MODE) begin
        set_frame_mode(directed_tab[i].val[1:0]);
      end else begin
        push_byte(directed_tab[i].val);
        made = deframe_byte(directed_tab[i].val, res);
        if (directed_tab[i].kind == ROW_GIVEN)
          deframed_q = {deframed_q, directed_tab[i].want};
        else if (directed_tab[i].kind == ROW_BYTE && made)
          deframed_q = {deframed_q, res};
      end
    end

    // Random framed traffic; each phase keeps whatever frame is in progress
    // across the mode change.
    foreach (phase_tab[p]) begin
      set_frame_mode(phase_tab[p].mode);
      idle_pct  = phase_tab[p].idle_pct;
      stall_pct = phase_tab[p].stall_pct;
      phase_end = rx_count + PHASE_ITEMS;
      while (rx_count < phase_end) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          // Line noise; keep start bytes out so noise never opens a huge frame.
          repeat ($urandom_range(1, 3)) begin
            res.fbyte = 8'($urandom_range(255));
            send_byte((res.fbyte == eafd_pkg::START_BYTE) ? 8'h00 : res.fbyte);
          end
        end else begin
          send_frame(($urandom_range(7) == 0) ? 16'($urandom_range(8, 60))
                                              : 16'($urandom_range(0, 6)), pick == 1);
        end
      end
    end

    drain();
    fail_count += deframed_q.size();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
hdl/eafd_pkg.sv
hdl/eafd_ifs.sv
hdl/eafd_front.sv
hdl/eafd_queue.sv
hdl/eafd_back.sv
hdl/escaped_api_frame_deframer_unit.sv
tb/testbench.sv
